@@ hdl/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg: shared constants and types of the synced timestamp clock
// Field widths, time constants, opcodes, register indexes and the status
// struct of the shared arithmetic units.
// ----------------------------------------------------------------------------
package stc_pkg;

  // widths
  localparam int unsigned TICK_WIDTH_DEF = 32;
  localparam int unsigned WORD_W         = 64;
  localparam int unsigned RATE_W         = 20;
  localparam int unsigned UTC_W          = 32;
  localparam int unsigned NOW_W          = 63;
  localparam int unsigned MONO_W         = 56;
  localparam int unsigned HNS_W          = 24;
  localparam int unsigned CHUNK_W        = 16;
  localparam int unsigned OPC_W          = 2;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;

  // time constants
  localparam logic [HNS_W-1:0]  HNS_PER_SEC = 24'd10000000;
  localparam logic [WORD_W-1:0] EPOCH_1601  = 64'd116444736000000000;
  localparam logic [RATE_W-1:0] RATE_RESET  = 20'd100;

  // opcodes
  localparam logic [OPC_W-1:0] OP_TICK = 2'd0;
  localparam logic [OPC_W-1:0] OP_SYNC = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUILD = 2'd1;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ hdl/stc_mulacc.sv @@
// ----------------------------------------------------------------------------
// stc_mulacc: chunked multiply-accumulate by 10^7
// Adds a * 10^7 to an initial value, modulo 2^64, one 16-bit chunk of a per
// cycle. done pulses in the cycle in which acc_o holds the final sum.
// ----------------------------------------------------------------------------
module stc_mulacc import stc_pkg::*; #(
  parameter int unsigned OP_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OP_W-1:0]   a_i,
  input  logic [WORD_W-1:0] init_i,
  output logic [WORD_W-1:0] acc_o,
  output unit_sts_t         sts_o
);

  localparam int unsigned NCHUNK = (OP_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned PAD_W  = NCHUNK * CHUNK_W;
  localparam int unsigned CNT_W  = $clog2(NCHUNK + 1);
  localparam int unsigned POS_W  = $clog2(PAD_W + 1);
  localparam int unsigned PROD_W = CHUNK_W + HNS_W;

  logic [PAD_W-1:0]  a_q;
  logic [WORD_W-1:0] acc_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [POS_W-1:0]  pos_q;
  logic              done_q;
  logic [PROD_W-1:0] prod;
  logic [WORD_W-1:0] term;

  // one partial product, weighted by its chunk position
  always_comb begin
    prod = PROD_W'(a_q[CHUNK_W-1:0]) * PROD_W'(HNS_PER_SEC);
    term = WORD_W'(prod) << pos_q;
  end

  // chunk sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(NCHUNK);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // operand and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= PAD_W'(a_i);
      acc_q <= init_i;
      pos_q <= '0;
    end else if (cnt_q != '0) begin
      a_q   <= a_q >> CHUNK_W;
      acc_q <= acc_q + term;
      pos_q <= pos_q + POS_W'(CHUNK_W);
    end
  end

  assign acc_o      = acc_q;
  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.done = done_q;

endmodule

@@ hdl/stc_div.sv @@
// ----------------------------------------------------------------------------
// stc_div: restoring divider, 64-bit dividend by 20-bit divisor
// One quotient bit per cycle. A zero divisor divides as one.
// ----------------------------------------------------------------------------
module stc_div import stc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [RATE_W-1:0] divisor_i,
  output logic [WORD_W-1:0] quo_o,
  output unit_sts_t         sts_o
);

  localparam int unsigned CNT_W = $clog2(WORD_W + 1);

  logic [RATE_W-1:0] rem_q;
  logic [RATE_W-1:0] dsr_q;
  logic [WORD_W-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              done_q;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              ge;

  // one restoring step
  always_comb begin
    trial = {rem_q, quo_q[WORD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(WORD_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsr_q <= (divisor_i == '0) ? RATE_W'(1) : divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quo_q <= {quo_q[WORD_W-2:0], ge};
    end
  end

  assign quo_o      = quo_q;
  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.done = done_q;

endmodule

@@ hdl/synced_timestamp_clock.sv @@
// ----------------------------------------------------------------------------
// synced_timestamp_clock: wall-clock timestamp unit
// Tick counter, sync offset and synced flag; every word in gives one word
// out with wall time and monotonic time in 100 ns units.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tuser opcode, tdata utc
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata now/mono, tuser sync
//   cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Order: an accepted input word goes through a chunked multiply pass by
// 10^7, the 64-step restoring divider, a second chunked multiply pass by
// 10^7 and the final step, which loads the result word into the output
// register. The next input word is taken once the sequencer is back in idle.
// Reset: asynchronous, clears counter, offset, synced flag, build and output valid; tps to 100.
// Stalls: no input word is taken while a word is in work; a finished word
// waits in the final step until the output register is free.
// cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module synced_timestamp_clock import stc_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [UTC_W-1:0]      s_axis_tdata,   // [31:0] utc_seconds
  input  logic [OPC_W-1:0]      s_axis_tuser,   // [1:0] opcode
  // result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [119:0]          m_axis_tdata,   // [62:0] now_time, [118:63] monotonic_time
  output logic                  m_axis_tuser,   // [0] is_synced
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned OP_W = (TICK_WIDTH > UTC_W) ? TICK_WIDTH : UTC_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULT = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MULB = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [WORD_W-1:0]     offset_q;
  logic                  synced_q;
  logic [OPC_W-1:0]      op_q;
  logic [UTC_W-1:0]      utc_q;
  logic [RATE_W-1:0]     tps_q;
  logic [UTC_W-1:0]      build_q;
  logic [WORD_W-1:0]     mono_q;
  logic                  out_valid_q;
  logic [NOW_W-1:0]      now_out_q;
  logic [MONO_W-1:0]     mono_out_q;
  logic                  syn_out_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  fin_go;
  logic                  mac_start;
  logic [OP_W-1:0]       mac_a;
  logic [WORD_W-1:0]     mac_init;
  logic [WORD_W-1:0]     mac_acc;
  unit_sts_t             mac_sts;
  logic                  div_start;
  logic [WORD_W-1:0]     div_quo;
  unit_sts_t             div_sts;
  logic [UTC_W-1:0]      base;
  logic                  is_sync_op;
  logic [WORD_W-1:0]     now_full;
  logic [WORD_W-1:0]     offset_new;

  // handshakes
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign fin_go        = (state_q == S_FIN) & out_free;

  // tick update on an accepted tick word
  assign tick_d = (in_acc && s_axis_tuser == OP_TICK) ? tick_q + TICK_WIDTH'(1) : tick_q;

  // shared unit operands
  always_comb begin
    is_sync_op = (op_q == OP_SYNC);
    base       = is_sync_op ? utc_q : build_q;
    mac_start  = in_acc | ((state_q == S_DIV) & div_sts.done);
    mac_a      = (state_q == S_IDLE) ? OP_W'(tick_d) : OP_W'(base);
    mac_init   = (state_q == S_IDLE) ? '0 : EPOCH_1601;
    div_start  = (state_q == S_MULT) & mac_sts.done;
  end

  // final sums: mac_acc holds base * 10^7 + epoch
  always_comb begin
    offset_new = mac_acc - mono_q;
    if (is_sync_op) begin
      now_full = mac_acc;
    end else if (synced_q) begin
      now_full = mono_q + offset_q;
    end else begin
      now_full = mono_q + mac_acc;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_MULT;
      S_MULT: if (mac_sts.done) state_d = S_DIV;
      S_DIV:  if (div_sts.done) state_d = S_MULB;
      S_MULB: if (mac_sts.done) state_d = S_FIN;
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= '0;
      offset_q    <= '0;
      synced_q    <= 1'b0;
      tps_q       <= RATE_RESET;
      build_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      if (fin_go && is_sync_op) begin
        offset_q <= offset_new;
        synced_q <= 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TPS:   tps_q   <= cfg_data_i[RATE_W-1:0];
          CFG_BUILD: build_q <= cfg_data_i[UTC_W-1:0];
          default:   ;
        endcase
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= s_axis_tuser;
      utc_q <= s_axis_tdata;
    end
    if ((state_q == S_DIV) && div_sts.done) begin
      mono_q <= div_quo;
    end
    if (fin_go) begin
      now_out_q  <= now_full[NOW_W-1:0];
      mono_out_q <= mono_q[MONO_W-1:0];
      syn_out_q  <= synced_q | is_sync_op;
    end
  end

  // ticks * 10^7, then base * 10^7 + epoch
  stc_mulacc #(
    .OP_W (OP_W)
  ) u_mulacc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mac_start),
    .a_i    (mac_a),
    .init_i (mac_init),
    .acc_o  (mac_acc),
    .sts_o  (mac_sts)
  );

  // conversion to 100 ns units
  stc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(mac_acc),
    .divisor_i (tps_q),
    .quo_o     (div_quo),
    .sts_o     (div_sts)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, mono_out_q, now_out_q};
  assign m_axis_tuser  = syn_out_q;

  // checks
  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (m_axis_tvalid && state_q == S_IDLE))
    else $error("finished word not loaded into output register");

  a_sync_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(synced_q))
    else $error("synced flag cleared outside reset");

  a_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(tick_q) |-> $past(in_acc && s_axis_tuser == OP_TICK))
    else $error("tick counter moved without a tick word");

  a_div_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == S_DIV))
    else $error("divider finished outside its phase");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mac_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

endmodule
